>>> rtl/agt_pkg.sv
`timescale 1ns / 1ps

package agt_pkg;

  localparam int CNT_W      = 16;
  localparam int RATE_W     = 20;
  localparam int AVG_W      = 26;
  localparam int SCALE_W    = 4;
  localparam int DVS_W      = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_USER_W = 2;

  localparam logic [CNT_W-1:0]   GATE_BASE_RST = 16'd6584;
  localparam logic [CNT_W-1:0]   REFRESH_RST   = 16'd1236;
  localparam logic [SCALE_W-1:0] SCALE_MIN_RST = 4'd4;
  localparam logic [SCALE_W-1:0] SCALE_MAX_RST = 4'd10;
  localparam logic [RATE_W-1:0]  RATE_MAX      = 20'hFFFFF;
  localparam logic [AVG_W-1:0]   RPM_FACTOR    = 26'd60;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GATE_BASE = 2'd0,
    REG_REFRESH   = 2'd1,
    REG_SCALE_MIN = 2'd2,
    REG_SCALE_MAX = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_ADIV,
    S_GDIV,
    S_OUT
  } agt_state_t;

  typedef struct packed {
    logic sum_start;
    logic push;
  } hist_ctrl_t;

  typedef struct packed {
    logic sum_done;
  } hist_stat_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/autoranging_gated_tachometer_top.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake                 Payload
// in_      in   in_tvalid / in_tready     tuser: op; tdata: hold
// out_     out  out_tvalid / out_tready   tuser: updated, sampled; tdata: avg, rate, scale
// cfg_     in   cfg_we                    cfg_addr, cfg_wdata
//
// Pulse request: accept, then S_OUT loads the result into the output register.
// Tick request: S_GDIV, then S_OUT; an average refresh adds S_SUM, S_ADIV first.
// Both divides share one bit-serial divider, RATE width + log2 D (23) bits; D = depth.
// Not ready from accept until the result sits in the output register.
// A stalled output holds the block in its last step; rst_n is synchronous.

module autoranging_gated_tachometer_top
  import agt_pkg::*;
#(
  parameter int HISTORY_DEPTH = 5,
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] hold
  input  logic [IN_USER_W-1:0]  in_tuser,   // [0] op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [25:0] average_rpm, [45:26] latest_rate,
                                            // [49:46] current_scale
  output logic [OUT_USER_W-1:0] out_tuser,  // [0] average_updated, [1] sample_taken
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SUM_W  = RATE_W + $clog2(HISTORY_DEPTH);
  localparam int DIV_W  = SUM_W;
  localparam int PROD_W = COUNTER_WIDTH + SCALE_W;
  localparam int CMP_W  = (PROD_W > RATE_W) ? PROD_W : RATE_W;

  agt_state_t state_r, state_nxt;

  logic [CNT_W-1:0]         gate_base_r, refresh_ticks_r;
  logic [SCALE_W-1:0]       scale_min_r, scale_max_r;
  logic [CNT_W-1:0]         gate_cnt_r, gate_cnt_nxt;
  logic [CNT_W-1:0]         refresh_cnt_r, refresh_cnt_nxt;
  logic [COUNTER_WIDTH-1:0] pulse_cnt_r, pulse_cnt_nxt;
  logic [SCALE_W-1:0]       scale_now_r, scale_now_nxt;
  logic [AVG_W-1:0]         average_r, average_nxt;
  logic                     hold_r, hold_nxt;
  logic                     updated_r, updated_nxt;
  logic                     sampled_r, sampled_nxt;
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic [OUT_USER_W-1:0]    out_user_r;

  hist_ctrl_t        hist_ctrl;
  hist_stat_t        hist_stat;
  div_ctrl_t         div_ctrl;
  div_stat_t         div_stat;
  logic [SUM_W-1:0]  hist_sum;
  logic [RATE_W-1:0] hist_latest;
  logic [DIV_W-1:0]  div_dividend, div_quo;
  logic [DVS_W-1:0]  div_divisor;

  logic                     accept, in_op, in_hold;
  logic                     div_sel_avg, avg_load, gate_eval, out_load;
  logic [SCALE_W-1:0]       scale_w, scale_src, scale_inc;
  logic [COUNTER_WIDTH-1:0] pulse_inc;
  logic [CNT_W-1:0]         refresh_inc;
  logic                     refresh_fire, gate_fire;
  logic [CMP_W-1:0]         prod;
  logic [RATE_W-1:0]        rate_val;

  assign in_op   = in_tuser[0];
  assign in_hold = in_tdata[0];
  assign accept  = in_tvalid && in_tready;

  assign scale_w      = in_hold ? scale_min_r : scale_now_r;
  assign pulse_inc    = pulse_cnt_r + 1'b1;
  assign refresh_inc  = refresh_cnt_r + 1'b1;
  assign refresh_fire = refresh_inc > refresh_ticks_r;
  assign scale_inc    = scale_w + 1'b1;
  assign gate_fire    = DIV_W'(gate_cnt_r) > div_quo;
  assign prod         = CMP_W'(pulse_cnt_r) * CMP_W'(scale_now_r);
  assign rate_val     = (prod > CMP_W'(RATE_MAX)) ? RATE_MAX : prod[RATE_W-1:0];

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_base_r     <= GATE_BASE_RST;
      refresh_ticks_r <= REFRESH_RST;
      scale_min_r     <= SCALE_MIN_RST;
      scale_max_r     <= SCALE_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_GATE_BASE: gate_base_r     <= cfg_wdata;
        REG_REFRESH:   refresh_ticks_r <= cfg_wdata;
        REG_SCALE_MIN: scale_min_r     <= cfg_wdata[SCALE_W-1:0];
        REG_SCALE_MAX: scale_max_r     <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op) state_nxt = S_OUT;
          else if (refresh_fire) state_nxt = S_SUM;
          else state_nxt = S_GDIV;
        end
      end
      S_SUM:  if (hist_stat.sum_done) state_nxt = S_ADIV;
      S_ADIV: if (div_stat.done) state_nxt = S_GDIV;
      S_GDIV: if (div_stat.done) state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready           = 1'b0;
    hist_ctrl.sum_start = 1'b0;
    hist_ctrl.push      = 1'b0;
    div_ctrl.start      = 1'b0;
    div_sel_avg         = 1'b0;
    avg_load            = 1'b0;
    gate_eval           = 1'b0;
    out_load            = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && !in_op) begin
          hist_ctrl.sum_start = refresh_fire;
          div_ctrl.start      = !refresh_fire;
        end
      end
      S_SUM: begin
        div_sel_avg    = 1'b1;
        div_ctrl.start = hist_stat.sum_done;
      end
      S_ADIV: begin
        avg_load       = div_stat.done;
        div_ctrl.start = div_stat.done;
      end
      S_GDIV: begin
        gate_eval      = div_stat.done;
        hist_ctrl.push = div_stat.done && gate_fire && !hold_r;
      end
      S_OUT: out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // divider operands
  always_comb begin
    scale_src    = (state_r == S_IDLE) ? scale_w : scale_now_r;
    div_dividend = div_sel_avg ? hist_sum : DIV_W'(gate_base_r);
    if (div_sel_avg) div_divisor = DVS_W'(HISTORY_DEPTH);
    else if (scale_src == '0) div_divisor = DVS_W'(1);
    else div_divisor = DVS_W'(scale_src);
  end

  // datapath
  always_comb begin
    gate_cnt_nxt    = gate_cnt_r;
    refresh_cnt_nxt = refresh_cnt_r;
    pulse_cnt_nxt   = pulse_cnt_r;
    scale_now_nxt   = scale_now_r;
    average_nxt     = average_r;
    hold_nxt        = hold_r;
    updated_nxt     = updated_r;
    sampled_nxt     = sampled_r;
    if (accept) begin
      hold_nxt    = in_hold;
      sampled_nxt = 1'b0;
      if (in_op) begin
        pulse_cnt_nxt = pulse_inc;
        updated_nxt   = 1'b0;
        if (in_hold) scale_now_nxt = scale_min_r;
        else if (pulse_inc == '0 && scale_w < scale_max_r) scale_now_nxt = scale_inc;
        else scale_now_nxt = scale_w;
      end else begin
        gate_cnt_nxt    = gate_cnt_r + 1'b1;
        refresh_cnt_nxt = refresh_fire ? '0 : refresh_inc;
        scale_now_nxt   = scale_w;
        updated_nxt     = refresh_fire;
      end
    end
    if (avg_load) average_nxt = AVG_W'(div_quo[RATE_W-1:0]) * RPM_FACTOR;
    if (gate_eval && gate_fire) begin
      gate_cnt_nxt  = '0;
      pulse_cnt_nxt = '0;
      sampled_nxt   = !hold_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      gate_cnt_r    <= '0;
      refresh_cnt_r <= '0;
      pulse_cnt_r   <= '0;
      scale_now_r   <= SCALE_MAX_RST;
      average_r     <= '0;
      hold_r        <= 1'b0;
      updated_r     <= 1'b0;
      sampled_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      gate_cnt_r    <= gate_cnt_nxt;
      refresh_cnt_r <= refresh_cnt_nxt;
      pulse_cnt_r   <= pulse_cnt_nxt;
      scale_now_r   <= scale_now_nxt;
      average_r     <= average_nxt;
      hold_r        <= hold_nxt;
      updated_r     <= updated_nxt;
      sampled_r     <= sampled_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {(OUT_DATA_W - AVG_W - RATE_W - SCALE_W)'(0),
                     scale_now_r, hist_latest, average_r};
      out_user_r <= {sampled_r, updated_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  agt_history #(
    .DEPTH (HISTORY_DEPTH),
    .SUM_W (SUM_W)
  ) u_history (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (hist_ctrl),
    .rate_in (rate_val),
    .stat    (hist_stat),
    .sum     (hist_sum),
    .latest  (hist_latest)
  );

  agt_divider #(
    .DIV_W (DIV_W)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready while a request is in progress");

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == S_ADIV || state_r == S_GDIV))
    else $error("divider running outside a divide step");

  a_hold_min_scale: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && hold_r |-> scale_now_r == scale_min_r)
    else $error("hold did not force minimum scale");

  a_sum_in_sum_state: assert property (@(posedge clk) disable iff (!rst_n)
    hist_stat.sum_done |-> state_r == S_SUM)
    else $error("history sum finished outside sum step");

endmodule

>>> rtl/agt_divider.sv
`timescale 1ns / 1ps

module agt_divider
  import agt_pkg::*;
#(
  parameter int DIV_W = 23
) (
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctrl_t        ctrl,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DIV_W);

  logic [DIV_W-1:0]    quo_r, quo_nxt;
  logic [DVS_W-1:0]    rem_r, rem_nxt;
  logic [DVS_W-1:0]    dvs_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r, done_r;
  logic [DVS_W:0]      rem_sh, diff;
  logic                ge;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    diff    = rem_sh - {1'b0, dvs_r};
    ge      = !diff[DVS_W];
    rem_nxt = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

>>> rtl/agt_history.sv
`timescale 1ns / 1ps

module agt_history
  import agt_pkg::*;
#(
  parameter int DEPTH = 5,
  parameter int SUM_W = 23
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hist_ctrl_t        ctrl,
  input  logic [RATE_W-1:0] rate_in,
  output hist_stat_t        stat,
  output logic [SUM_W-1:0]  sum,
  output logic [RATE_W-1:0] latest
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [RATE_W-1:0] hist_r [DEPTH];
  logic [IDX_W-1:0]  idx_r;
  logic [SUM_W-1:0]  acc_r;
  logic              busy_r, done_r;

  // shift line of samples, newest at entry 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) hist_r[i] <= '0;
    end else if (ctrl.push) begin
      hist_r[0] <= rate_in;
      for (int i = 1; i < DEPTH; i++) hist_r[i] <= hist_r[i-1];
    end
  end

  // one entry added per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.sum_start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == IDX_W'(DEPTH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_start) begin
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + SUM_W'(hist_r[idx_r]);
    end
  end

  assign stat.sum_done = done_r;
  assign sum           = acc_r;
  assign latest        = hist_r[0];

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import agt_pkg::*;

  localparam int  HIST_DEPTH = 5;
  localparam int  PULSE_W    = 16;
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_PULSE  = 1'b1;

  typedef struct packed {
    logic [AVG_W-1:0]   avg_rpm;
    logic [RATE_W-1:0]  rate;
    logic [SCALE_W-1:0] scale;
    logic               updated;
    logic               sampled;
  } tach_reading_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_we     = 1'b0;
  cfg_reg_t              cfg_addr   = REG_GATE_BASE;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int err_cnt      = 0;

  tach_reading_t expected_readings[$];

  // shadow of the block
  logic [CNT_W-1:0]   set_gate_base;
  logic [CNT_W-1:0]   set_refresh;
  logic [SCALE_W-1:0] set_scale_min;
  logic [SCALE_W-1:0] set_scale_max;
  logic [CNT_W-1:0]   gate_cnt;
  logic [CNT_W-1:0]   refresh_cnt;
  logic [PULSE_W-1:0] pulse_cnt;
  logic [SCALE_W-1:0] scale_now;
  logic [RATE_W-1:0]  rate_hist [HIST_DEPTH];
  logic [AVG_W-1:0]   avg_rpm;

  autoranging_gated_tachometer_top #(
    .HISTORY_DEPTH(HIST_DEPTH),
    .COUNTER_WIDTH(PULSE_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  task automatic tach_model_reset();
    set_gate_base = GATE_BASE_RST;
    set_refresh   = REFRESH_RST;
    set_scale_min = SCALE_MIN_RST;
    set_scale_max = SCALE_MAX_RST;
    gate_cnt      = '0;
    refresh_cnt   = '0;
    pulse_cnt     = '0;
    scale_now     = SCALE_MAX_RST;
    avg_rpm       = '0;
    for (int i = 0; i < HIST_DEPTH; i++) rate_hist[i] = '0;
  endtask

  task automatic advance_tachometer(input logic op, input logic hold,
                                    output tach_reading_t r);
    int unsigned        hist_sum;
    logic [SCALE_W-1:0] divisor;
    logic [31:0]        product;
    r.updated = 1'b0;
    r.sampled = 1'b0;
    if (hold) scale_now = set_scale_min;
    if (op == OP_PULSE) begin
      pulse_cnt = pulse_cnt + 1'b1;
      if (pulse_cnt == '0 && scale_now < set_scale_max) scale_now = scale_now + 1'b1;
    end else begin
      gate_cnt    = gate_cnt + 1'b1;
      refresh_cnt = refresh_cnt + 1'b1;
      if (refresh_cnt > set_refresh) begin
        refresh_cnt = '0;
        hist_sum = 0;
        for (int i = 0; i < HIST_DEPTH; i++) hist_sum += rate_hist[i];
        avg_rpm = AVG_W'((hist_sum / HIST_DEPTH) * RPM_FACTOR);
        r.updated = 1'b1;
      end
      divisor = (scale_now != '0) ? scale_now : SCALE_W'(1);
      if (gate_cnt > set_gate_base / divisor) begin
        gate_cnt = '0;
        if (!hold) begin
          product = 32'(pulse_cnt) * 32'(scale_now);
          if (product > RATE_MAX) product = RATE_MAX;
          for (int i = HIST_DEPTH - 1; i > 0; i--) rate_hist[i] = rate_hist[i-1];
          rate_hist[0] = product[RATE_W-1:0];
          r.sampled = 1'b1;
        end
        pulse_cnt = '0;
      end
    end
    if (hold) scale_now = set_scale_min;
    r.avg_rpm = avg_rpm;
    r.rate    = rate_hist[0];
    r.scale   = scale_now;
  endtask

  task automatic send_event(input logic op, input logic hold);
    tach_reading_t want;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W-1){1'b0}}, hold};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_tachometer(op, hold, want);
    expected_readings.push_back(want);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller lowers it
  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_GATE_BASE: set_gate_base = val;
      REG_REFRESH:   set_refresh   = val;
      REG_SCALE_MIN: set_scale_min = val[SCALE_W-1:0];
      REG_SCALE_MAX: set_scale_max = val[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CNT_W-1:0] gate_base, input logic [CNT_W-1:0] refresh,
                           input logic [SCALE_W-1:0] smin, input logic [SCALE_W-1:0] smax);
    drain_results();
    put_reg(REG_GATE_BASE, gate_base);
    put_reg(REG_REFRESH, refresh);
    put_reg(REG_SCALE_MIN, CFG_DATA_W'(smin));
    put_reg(REG_SCALE_MAX, CFG_DATA_W'(smax));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random_events(input int count, input int pulse_pct, input int hold_pct);
    logic op;
    logic hold;
    for (int n = 0; n < count; n++) begin
      op   = ($urandom_range(99) < pulse_pct) ? OP_PULSE : OP_TICK;
      hold = ($urandom_range(99) < hold_pct);
      send_event(op, hold);
    end
  endtask

  task automatic test_reset_values();
    send_event(OP_PULSE, 1'b0);
    send_event(OP_TICK, 1'b0);
    send_event(OP_PULSE, 1'b1);
    send_event(OP_TICK, 1'b1);
  endtask

  task automatic test_gate_and_average();
    configure(16'd1, 16'd1, 4'd1, 4'd15);
    repeat (3) send_event(OP_PULSE, 1'b0);
    send_event(OP_TICK, 1'b0);
    send_event(OP_PULSE, 1'b1);
    repeat (2) send_event(OP_PULSE, 1'b0);
    send_event(OP_TICK, 1'b0);
    // gate closes under hold: no sample, count still cleared
    repeat (2) send_event(OP_PULSE, 1'b0);
    send_event(OP_TICK, 1'b1);
    repeat (3) send_event(OP_TICK, 1'b0);
  endtask

  task automatic test_random_traffic();
    snd_idle_pct = 22;
    rcv_idle_pct = 63;
    configure(16'd1, 16'd1, 4'd1, 4'd15);
    run_random_events(310, 70, 8);
    configure(16'd20, 16'd7, 4'd3, 4'd6);
    run_random_events(310, 80, 12);
    snd_idle_pct = 63;
    rcv_idle_pct = 22;
    configure(16'd200, 16'd33, 4'd15, 4'd15);
    run_random_events(310, 75, 10);
    // minimum above maximum
    configure(16'd5, 16'd2, 4'd9, 4'd2);
    run_random_events(310, 60, 15);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    configure(16'd50, 16'd20, 4'd4, 4'd10);
    run_random_events(310, 85, 6);
  endtask

  task automatic test_max_thresholds();
    // thresholds at full scale: neither gate nor refresh fires
    configure(16'hFFFF, 16'hFFFF, 4'd2, 4'd15);
    repeat (6) send_event(OP_PULSE, 1'b0);
    repeat (4) send_event(OP_TICK, 1'b0);
    send_event(OP_PULSE, 1'b1);
    send_event(OP_TICK, 1'b1);
    // scale above the lowered maximum
    configure(16'hFFFF, 16'hFFFF, 4'd2, 4'd1);
    repeat (4) send_event(OP_PULSE, 1'b0);
    send_event(OP_TICK, 1'b0);
  endtask

  always @(posedge clk) begin : check_readings
    tach_reading_t got;
    tach_reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.avg_rpm = out_tdata[AVG_W-1:0];
      got.rate    = out_tdata[AVG_W +: RATE_W];
      got.scale   = out_tdata[AVG_W+RATE_W +: SCALE_W];
      got.updated = out_tuser[0];
      got.sampled = out_tuser[1];
      if (expected_readings.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected reading: avg=%0d rate=%0d scale=%0d upd=%b smp=%b",
                   got.avg_rpm, got.rate, got.scale, got.updated, got.sampled);
      end else begin
        want = expected_readings.pop_front();
        if (got.avg_rpm !== want.avg_rpm || got.rate !== want.rate ||
            got.scale !== want.scale || got.updated !== want.updated ||
            got.sampled !== want.sampled) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("reading mismatch: exp avg=%0d rate=%0d scale=%0d upd=%b smp=%b",
                     want.avg_rpm, want.rate, want.scale, want.updated, want.sampled,
                     ", got avg=%0d rate=%0d scale=%0d upd=%b smp=%b",
                     got.avg_rpm, got.rate, got.scale, got.updated, got.sampled);
        end
      end
    end
  end

  initial begin
    tach_model_reset();
    snd_idle_pct = 22;
    rcv_idle_pct = 63;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_gate_and_average();
    test_random_traffic();
    test_max_thresholds();
    drain_results();
    repeat (60) @(posedge clk);
    err_cnt += expected_readings.size();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> autoranging_gated_tachometer_top.f
rtl/agt_pkg.sv
rtl/agt_divider.sv
rtl/agt_history.sv
rtl/autoranging_gated_tachometer_top.sv
tb/sv/testbench.sv
